[src/dda_line_rasterizer_core_assert.svh]
// assertion helpers for the dda line rasterizer
`ifndef DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DDA_LINE_RASTERIZER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define DDA_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dda assertion failed");

// next-cycle implication, held off during reset
`define DDA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dda assertion failed");

`endif

[src/dda_pkg.sv]
// ----------------------------------------------------------------------------
// dda_pkg
// shared types and constants of the dda line rasterizer
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int unsigned CoordBits = 12;

  typedef logic signed [CoordBits-1:0] coord_t;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdTick  = 1'b1;

  typedef struct packed {
    logic   cmd;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_req_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_rsp_t;

  // request to the shared divider
  typedef struct packed {
    logic                 start;
    logic [CoordBits-1:0] dividend;
    logic [CoordBits-1:0] divisor;
  } div_req_t;

endpackage

[src/dda_div.sv]
// ----------------------------------------------------------------------------
// dda_div
// restoring divider, one quotient bit per cycle: (dividend << FRAC_BITS) / divisor
// for dividend <= divisor, giving a FRAC_BITS+1 bit quotient
// ----------------------------------------------------------------------------
module dda_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dda_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [FRAC_BITS:0] quo_o
);
  import dda_pkg::*;

  localparam int unsigned CntW = $clog2(FRAC_BITS + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(FRAC_BITS);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CoordBits-1:0] rem_q, rem_d;
  logic [CoordBits-1:0] dvs_q, dvs_d;
  logic [FRAC_BITS:0]   quo_q, quo_d;
  logic [CoordBits:0]   trial;
  logic [CoordBits:0]   diff;
  logic                 ge;

  // first step compares the dividend itself, later ones the doubled remainder
  assign trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[CoordBits-1:0] : trial[CoordBits-1:0];
      quo_d = {quo_q[FRAC_BITS-1:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[src/dda_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core
// dda line rasterizer: start requests set up a line, tick requests step it
// ----------------------------------------------------------------------------
// input channel: in_valid_i/in_ready_o carry an in_req_t. cmd CmdStart begins a
//   line from start to end, cmd CmdTick asks for the next pixel.
// output channel: out_valid_o/out_ready_i carry an out_rsp_t with one pixel.
// a start request returns the start pixel in the cycle after acceptance. the two
//   per-axis increments then come from one shared bit-serial divider, run for
//   x and then for y, so the block takes no request until both divisions are
//   done. a zero-length line returns one pixel marked last and takes no
//   divider time.
// a tick request returns its pixel in the cycle after acceptance; ticks can be
//   taken every cycle unless stalled; a tick with no line in progress returns nothing.
// a start request abandons any line in progress.
// a stalled output holds its pixel; a new request is taken only while the
//   output register is empty or being emptied in the same cycle.
// reset leaves the block idle with no line in progress and no pixel pending.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dda_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dda_pkg::out_rsp_t out_rsp_o
);
  import dda_pkg::*;

  localparam int unsigned PosW  = CoordBits + FRAC_BITS + 1;
  localparam int unsigned QuoW  = FRAC_BITS + 1;
  localparam int unsigned StepW = FRAC_BITS + 2;
  localparam logic [PosW-1:0] HalfV = PosW'(1) << (FRAC_BITS - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDivX = 2'd1;
  localparam logic [1:0] StDivY = 2'd2;

  // round half away from zero: negative values need one less before the floor
  function automatic coord_t round_pix(logic signed [PosW-1:0] p);
    logic [PosW-1:0] r;
    r = p + HalfV - {{(PosW-1){1'b0}}, p[PosW-1]};
    return r[FRAC_BITS +: CoordBits];
  endfunction

  logic [1:0]               state_q, state_d;
  logic                     active_q, active_d;
  logic [CoordBits-1:0]     steps_left_q, steps_left_d;
  logic                     out_valid_q, out_valid_d;
  out_rsp_t                 out_rsp_q, out_rsp_d;
  logic signed [PosW-1:0]   pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [StepW-1:0]  step_x_q, step_x_d, step_y_q, step_y_d;
  logic                     neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [CoordBits-1:0]     mag_y_q, mag_y_d;
  logic [CoordBits-1:0]     steps_q, steps_d;

  logic [CoordBits:0]       dx, dy, dx_abs, dy_abs;
  logic [CoordBits-1:0]     mag_x, mag_y, steps;
  logic                     zero_len;
  logic                     in_acc;
  logic signed [PosW-1:0]   pos_x_nxt, pos_y_nxt;
  logic                     div_done;
  logic [QuoW-1:0]          quo;
  logic [StepW-1:0]         quo_ext, step_new;
  logic                     neg_cur;
  div_req_t                 div_req;

  assign dx = {in_req_i.end_x[CoordBits-1], in_req_i.end_x}
            - {in_req_i.start_x[CoordBits-1], in_req_i.start_x};
  assign dy = {in_req_i.end_y[CoordBits-1], in_req_i.end_y}
            - {in_req_i.start_y[CoordBits-1], in_req_i.start_y};
  assign dx_abs   = dx[CoordBits] ? (~dx + 1'b1) : dx;
  assign dy_abs   = dy[CoordBits] ? (~dy + 1'b1) : dy;
  assign mag_x    = dx_abs[CoordBits-1:0];
  assign mag_y    = dy_abs[CoordBits-1:0];
  assign steps    = (mag_x > mag_y) ? mag_x : mag_y;
  assign zero_len = (steps == '0);

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign pos_x_nxt = pos_x_q + PosW'(step_x_q);
  assign pos_y_nxt = pos_y_q + PosW'(step_y_q);

  // signed increment from the unsigned quotient of the axis in flight
  assign neg_cur  = (state_q == StDivX) ? neg_x_q : neg_y_q;
  assign quo_ext  = {1'b0, quo};
  assign step_new = neg_cur ? (~quo_ext + 1'b1) : quo_ext;

  always_comb begin
    div_req.start    = (in_acc && (in_req_i.cmd == CmdStart) && !zero_len)
                     || ((state_q == StDivX) && div_done);
    div_req.dividend = (state_q == StDivX) ? mag_y_q : mag_x;
    div_req.divisor  = (state_q == StDivX) ? steps_q : steps;
  end

  dda_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quo_o (quo)
  );

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    steps_left_d = steps_left_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_rsp_d    = out_rsp_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    step_x_d     = step_x_q;
    step_y_d     = step_y_q;
    neg_x_d      = neg_x_q;
    neg_y_d      = neg_y_q;
    mag_y_d      = mag_y_q;
    steps_d      = steps_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_req_i.cmd == CmdStart) begin
            pos_x_d              = {in_req_i.start_x[CoordBits-1], in_req_i.start_x,
                                    {FRAC_BITS{1'b0}}};
            pos_y_d              = {in_req_i.start_y[CoordBits-1], in_req_i.start_y,
                                    {FRAC_BITS{1'b0}}};
            out_valid_d          = 1'b1;
            out_rsp_d.pixel_x    = in_req_i.start_x;
            out_rsp_d.pixel_y    = in_req_i.start_y;
            out_rsp_d.last_pixel = zero_len;
            active_d             = 1'b0;
            steps_left_d         = steps;
            neg_x_d              = dx[CoordBits];
            neg_y_d              = dy[CoordBits];
            mag_y_d              = mag_y;
            steps_d              = steps;
            if (zero_len) begin
              step_x_d = '0;
              step_y_d = '0;
            end else begin
              state_d = StDivX;
            end
          end else if (active_q) begin
            pos_x_d              = pos_x_nxt;
            pos_y_d              = pos_y_nxt;
            steps_left_d         = steps_left_q - 1'b1;
            active_d             = (steps_left_q != CoordBits'(1));
            out_valid_d          = 1'b1;
            out_rsp_d.pixel_x    = round_pix(pos_x_nxt);
            out_rsp_d.pixel_y    = round_pix(pos_y_nxt);
            out_rsp_d.last_pixel = (steps_left_q == CoordBits'(1));
          end
        end
      end
      StDivX: begin
        if (div_done) begin
          step_x_d = step_new;
          state_d  = StDivY;
        end
      end
      StDivY: begin
        if (div_done) begin
          step_y_d = step_new;
          active_d = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      active_q     <= 1'b0;
      steps_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      steps_left_q <= steps_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    pos_x_q   <= pos_x_d;
    pos_y_q   <= pos_y_d;
    step_x_q  <= step_x_d;
    step_y_q  <= step_y_d;
    neg_x_q   <= neg_x_d;
    neg_y_q   <= neg_y_d;
    mag_y_q   <= mag_y_d;
    steps_q   <= steps_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

[src/dda_chk.sv]
// ----------------------------------------------------------------------------
// dda_chk
// port-level checks of the dda line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_core_assert.svh"

module dda_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input dda_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dda_pkg::out_rsp_t out_rsp_o
);
  import dda_pkg::*;

  logic start_acc;
  logic long_line;

  assign start_acc = in_valid_i && in_ready_o && (in_req_i.cmd == CmdStart);
  assign long_line = (in_req_i.start_x != in_req_i.end_x)
                  || (in_req_i.start_y != in_req_i.end_y);

  // stalled pixel stays put
  `DDA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_rsp_o))

  // start pixel comes out right away with the start coordinates
  `DDA_ASSERT_NEXT(a_start_pixel, clk_i, rst_ni, start_acc,
                   out_valid_o && (out_rsp_o.pixel_x == $past(in_req_i.start_x))
                   && (out_rsp_o.pixel_y == $past(in_req_i.start_y)))

  // last flag on the start pixel only for a zero-length line
  `DDA_ASSERT_NEXT(a_start_last, clk_i, rst_ni, start_acc,
                   out_rsp_o.last_pixel == !$past(long_line))

  // a real line has the input closed as soon as its start is taken
  `DDA_ASSERT_NEXT(a_setup_busy, clk_i, rst_ni, start_acc && long_line, !in_ready_o)

endmodule

bind dda_line_rasterizer_core dda_chk u_dda_chk (.*);
